>>> sv/stis_pkg.sv
`default_nettype none

package stis_pkg;

    // Field widths of one item
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 10;
    localparam int STAT_W  = 2;

    // Default table depth and query queue depth
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 2;

    // Operation codes carried in the low tuser bit
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNSORTED  = 2'd2;

    // Search engine states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

>>> sv/sorted_table_interval_search.sv
// Sorted-table interval search. Load items (tuser bit 0 low) write signed 32-bit entries into
// an on-chip table in arrival order; tuser bit 1 on a load restarts the table at index zero,
// and loads past TableDepth entries are dropped. The block tracks whether the loaded entries
// are non-decreasing. A query item (tuser bit 0 high) with key x returns one result: status
// found with indices j and j+1 where table[j] <= x < table[j+1], not found when no such pair
// lies inside the table, or not sorted. A load produces no result. Queries pass through a
// two-entry queue to a binary search engine that issues one table read per cycle while it
// searches, through the single read port of the table memory. A load is taken once all
// earlier queries have left the queue and the search engine. Indices are reported modulo 1024.
`default_nettype none

module sorted_table_interval_search #(
    parameter int TableDepth = stis_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [0] op, [1] is_first
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [9:0] low_index, [19:10] high_index, [23:20] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int AddrW  = $clog2(TableDepth);
    localparam int CountW = $clog2(TableDepth + 1);
    localparam int QueryW = stis_pkg::VALUE_W + CountW + 1;

    logic                          wr_en;
    logic [AddrW-1:0]              wr_addr;
    logic [stis_pkg::VALUE_W-1:0]  wr_data;
    logic                          q_push;
    logic [QueryW-1:0]             q_push_data;
    logic                          q_ready;
    logic                          q_empty;
    logic                          q_pop;
    logic                          q_valid;
    logic [QueryW-1:0]             q_pop_data;
    logic                          back_busy;

    stis_front #(
        .TableDepth (TableDepth),
        .AddrW      (AddrW),
        .CountW     (CountW),
        .QueryW     (QueryW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_ready     (q_ready),
        .q_empty     (q_empty),
        .back_busy   (back_busy)
    );

    stis_queue #(
        .Width (QueryW),
        .Depth (stis_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .ready     (q_ready),
        .empty     (q_empty),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    stis_back #(
        .TableDepth (TableDepth),
        .AddrW      (AddrW),
        .CountW     (CountW),
        .QueryW     (QueryW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .q_valid  (q_valid),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .busy     (back_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> sv/stis_front.sv
`default_nettype none

module stis_front #(
    parameter int TableDepth = stis_pkg::TABLE_DEPTH_DEF,
    parameter int AddrW      = $clog2(TableDepth),
    parameter int CountW     = $clog2(TableDepth + 1),
    parameter int QueryW     = stis_pkg::VALUE_W + CountW + 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input item
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [stis_pkg::VALUE_W-1:0]  s_tdata,
    input  wire logic [1:0]                    s_tuser,
    // table write port
    output logic                               wr_en,
    output logic [AddrW-1:0]                   wr_addr,
    output logic [stis_pkg::VALUE_W-1:0]       wr_data,
    // query queue push side
    output logic                               q_push,
    output logic [QueryW-1:0]                  q_push_data,
    input  wire logic                          q_ready,
    input  wire logic                          q_empty,
    input  wire logic                          back_busy
);

    logic [CountW-1:0]                  count_reg, count_next;
    logic signed [stis_pkg::VALUE_W-1:0] prev_reg, prev_next;
    logic                               order_ok_reg, order_ok_next;

    logic                               is_query;
    logic                               is_first;
    logic                               accept;
    logic signed [stis_pkg::VALUE_W-1:0] value;

    assign is_query = (s_tuser[0] == stis_pkg::OP_QUERY);
    assign is_first = s_tuser[1];
    assign value    = $signed(s_tdata);

    // Hold loads until every earlier query has left the queue and the search engine
    assign s_tready = is_query ? q_ready : (q_empty && !back_busy);
    assign accept   = s_tvalid && s_tready;

    // Queue a query with a snapshot of the table size and order flag
    assign q_push      = accept && is_query;
    assign q_push_data = {order_ok_reg, count_reg, s_tdata};

    // Track table size, last entry and order flag on loads
    always_comb begin
        count_next    = count_reg;
        prev_next     = prev_reg;
        order_ok_next = order_ok_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AddrW-1:0];
        wr_data       = s_tdata;
        if (accept && !is_query) begin
            if (is_first) begin
                wr_en         = 1'b1;
                wr_addr       = '0;
                count_next    = CountW'(1);
                prev_next     = value;
                order_ok_next = 1'b1;
            end else if (count_reg < CountW'(TableDepth)) begin
                wr_en      = 1'b1;
                count_next = count_reg + CountW'(1);
                prev_next  = value;
                if ((count_reg != '0) && (value < prev_reg)) begin
                    order_ok_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            prev_reg     <= '0;
            order_ok_reg <= 1'b1;
        end else begin
            count_reg    <= count_next;
            prev_reg     <= prev_next;
            order_ok_reg <= order_ok_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/stis_queue.sv
`default_nettype none

module stis_queue #(
    parameter int Width = 8,
    parameter int Depth = stis_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [Width-1:0] push_data,
    output logic                  ready,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  valid,
    output logic [Width-1:0]      pop_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] slot_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign ready    = (cnt_reg != CntW'(Depth));
    assign empty    = (cnt_reg == '0);
    assign valid    = !empty;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/stis_back.sv
`default_nettype none

module stis_back #(
    parameter int TableDepth = stis_pkg::TABLE_DEPTH_DEF,
    parameter int AddrW      = $clog2(TableDepth),
    parameter int CountW     = $clog2(TableDepth + 1),
    parameter int QueryW     = stis_pkg::VALUE_W + CountW + 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // table write port
    input  wire logic                          wr_en,
    input  wire logic [AddrW-1:0]              wr_addr,
    input  wire logic [stis_pkg::VALUE_W-1:0]  wr_data,
    // query queue pop side
    input  wire logic                          q_valid,
    input  wire logic [QueryW-1:0]             q_data,
    output logic                               q_pop,
    output logic                               busy,
    // result item
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,
    output logic [stis_pkg::STAT_W-1:0]        m_tuser
);

    localparam int VW  = stis_pkg::VALUE_W;
    localparam int IW  = stis_pkg::IDX_W;
    localparam int SW  = stis_pkg::STAT_W;
    localparam int UXW = CountW + IW;

    // Table memory
    logic [VW-1:0] mem [TableDepth];
    logic [VW-1:0] rdata_reg;
    logic          rd_en;
    logic [AddrW-1:0] rd_addr;

    stis_pkg::back_state_t state_reg, state_next;

    logic signed [VW-1:0] key_reg, key_next;
    logic [CountW-1:0]    count_reg, count_next;
    logic [CountW-1:0]    lo_reg, lo_next;
    logic [CountW-1:0]    hi_reg, hi_next;
    logic [AddrW-1:0]     mid_reg, mid_next;
    logic [SW-1:0]        res_status_reg, res_status_next;
    logic [CountW-1:0]    res_ub_reg, res_ub_next;

    logic                 out_valid_reg, out_valid_next;
    logic [23:0]          out_data_reg, out_data_next;
    logic [SW-1:0]        out_user_reg, out_user_next;

    // Query fields popped from the queue
    logic signed [VW-1:0] q_key;
    logic [CountW-1:0]    q_count;
    logic                 q_sorted;
    logic [AddrW-1:0]     start_mid;

    // One bisection step
    logic                 le;
    logic [CountW-1:0]    mid_cw;
    logic [CountW-1:0]    step_lo, step_hi;
    logic [CountW:0]      mid_sum;
    logic [AddrW-1:0]     mid_new;
    logic                 step_done;
    logic                 out_free;

    // Result index formatting
    logic [UXW-1:0]       ub_ext;
    logic [UXW-1:0]       lb_ext;

    assign q_key     = $signed(q_data[VW-1:0]);
    assign q_count   = q_data[VW +: CountW];
    assign q_sorted  = q_data[VW + CountW];
    assign start_mid = AddrW'(q_count >> 1);

    assign le        = ($signed(rdata_reg) <= key_reg);
    assign mid_cw    = CountW'(mid_reg);
    assign step_lo   = le ? (mid_cw + CountW'(1)) : lo_reg;
    assign step_hi   = le ? hi_reg : mid_cw;
    assign mid_sum   = {1'b0, step_lo} + {1'b0, step_hi};
    assign mid_new   = mid_sum[AddrW:1];
    assign step_done = (step_lo == step_hi);
    assign out_free  = !out_valid_reg || m_tready;

    assign ub_ext = UXW'(res_ub_reg);
    assign lb_ext = ub_ext - UXW'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stis_pkg::BK_IDLE: begin
                if (q_valid) begin
                    if (!q_sorted || (q_count < CountW'(2))) begin
                        state_next = stis_pkg::BK_DONE;
                    end else begin
                        state_next = stis_pkg::BK_SEARCH;
                    end
                end
            end
            stis_pkg::BK_SEARCH: begin
                if (step_done) begin
                    state_next = stis_pkg::BK_DONE;
                end
            end
            stis_pkg::BK_DONE: begin
                if (out_free) begin
                    state_next = stis_pkg::BK_IDLE;
                end
            end
            default: state_next = stis_pkg::BK_IDLE;
        endcase
    end

    // State outputs: queue pop and memory read
    always_comb begin
        q_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = mid_new;
        busy    = (state_reg != stis_pkg::BK_IDLE);
        unique case (state_reg)
            stis_pkg::BK_IDLE: begin
                q_pop   = q_valid;
                rd_en   = q_valid;
                rd_addr = start_mid;
            end
            stis_pkg::BK_SEARCH: begin
                rd_en = !step_done;
            end
            stis_pkg::BK_DONE: begin
                rd_en = 1'b0;
            end
            default: rd_en = 1'b0;
        endcase
    end

    // Search datapath
    always_comb begin
        key_next        = key_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        res_status_next = res_status_reg;
        res_ub_next     = res_ub_reg;
        if ((state_reg == stis_pkg::BK_IDLE) && q_valid) begin
            key_next    = q_key;
            count_next  = q_count;
            lo_next     = '0;
            hi_next     = q_count;
            mid_next    = start_mid;
            res_ub_next = '0;
            if (!q_sorted) begin
                res_status_next = stis_pkg::ST_UNSORTED;
            end else begin
                res_status_next = stis_pkg::ST_NOT_FOUND;
            end
        end else if (state_reg == stis_pkg::BK_SEARCH) begin
            lo_next  = step_lo;
            hi_next  = step_hi;
            mid_next = mid_new;
            if (step_done) begin
                res_ub_next = step_lo;
                // First entry above the key must lie strictly inside the table
                if ((step_lo != '0) && (step_lo != count_reg)) begin
                    res_status_next = stis_pkg::ST_FOUND;
                end else begin
                    res_status_next = stis_pkg::ST_NOT_FOUND;
                end
            end
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == stis_pkg::BK_DONE) && out_free) begin
            out_valid_next = 1'b1;
            out_user_next  = res_status_reg;
            if (res_status_reg == stis_pkg::ST_FOUND) begin
                out_data_next = {4'b0, ub_ext[IW-1:0], lb_ext[IW-1:0]};
            end else begin
                out_data_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= stis_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        count_reg      <= count_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_status_reg <= res_status_next;
        res_ub_reg     <= res_ub_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

>>> sv/stis_checker.sv
`default_nettype none

module stis_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // No result item right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    // Only defined status codes appear
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == stis_pkg::ST_FOUND) || (m_tuser == stis_pkg::ST_NOT_FOUND)
                     || (m_tuser == stis_pkg::ST_UNSORTED))
        else $error("undefined status code");

    // Found interval indices are neighbors
    a_adjacent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == stis_pkg::ST_FOUND)
            |-> m_tdata[19:10] == (m_tdata[9:0] + 10'd1))
        else $error("interval indices not adjacent");

    // Indices are zero unless an interval was found
    a_zero_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != stis_pkg::ST_FOUND) |-> m_tdata == 24'd0)
        else $error("indices set without a found interval");

endmodule

bind sorted_table_interval_search stis_checker u_stis_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
